// ===== hdl/ssf_pkg.sv =====
`default_nettype none
package ssf_pkg;

	// Key and mask widths of one table entry
	localparam int ID_BITS      = 16;
	localparam int MASK_BITS    = 32;
	localparam int CAPACITY_DEF = 32;
	localparam int RESULT_LIMIT = 32;
	localparam int MATCH_W      = $clog2(RESULT_LIMIT + 1);

	// Stream widths
	localparam int S_TDATA_W = 2 * ID_BITS + 2 * MASK_BITS;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 2 * ID_BITS;
	localparam int M_TUSER_W = 3;

	// Operation codes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_PROC = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [MASK_BITS-1:0] mask;
		logic [ID_BITS-1:0]   data;
		logic [ID_BITS-1:0]   handler;
	} entry_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               hit;
		logic [ID_BITS-1:0] handler;
		logic [ID_BITS-1:0] data;
		logic               last;
	} result_t;

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int cnt_w(input int depth);
		return $clog2(depth + 1);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ssf_table.sv =====
`default_nettype none
module ssf_table #(
	parameter int CAPACITY = ssf_pkg::CAPACITY_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [ssf_pkg::addr_w(CAPACITY)-1:0]  waddr,
	input  wire ssf_pkg::entry_t                       wdata,
	input  wire logic                                  re,
	input  wire logic [ssf_pkg::addr_w(CAPACITY)-1:0]  raddr,
	output ssf_pkg::entry_t                            rdata
);
	import ssf_pkg::*;

	entry_t mem_q [CAPACITY];

	// Single write port, single registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ssf_out_reg.sv =====
`default_nettype none
module ssf_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ssf_pkg::result_t res,
	output logic                  push_ok,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ssf_pkg::result_t      out_res
);
	import ssf_pkg::*;

	logic valid_q;

	assign push_ok   = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_res <= res;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ssf_seq.sv =====
`default_nettype none
module ssf_seq #(
	parameter int CAPACITY = ssf_pkg::CAPACITY_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic [1:0]                              in_op,
	input  wire logic [ssf_pkg::ID_BITS-1:0]             in_handler,
	input  wire logic [ssf_pkg::ID_BITS-1:0]             in_data,
	input  wire logic [ssf_pkg::MASK_BITS-1:0]           in_mask,
	input  wire logic [ssf_pkg::MASK_BITS-1:0]           in_event,
	output logic                                         mem_we,
	output logic [ssf_pkg::addr_w(CAPACITY)-1:0]         mem_waddr,
	output ssf_pkg::entry_t                              mem_wdata,
	output logic                                         mem_re,
	output logic [ssf_pkg::addr_w(CAPACITY)-1:0]         mem_raddr,
	input  wire ssf_pkg::entry_t                         mem_rdata,
	output logic                                         res_valid,
	output ssf_pkg::result_t                             res,
	input  wire logic                                    push_ok
);
	import ssf_pkg::*;

	localparam int AW    = addr_w(CAPACITY);
	localparam int CNT_W = cnt_w(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE, S_PROBE, S_CMP, S_SH_INIT, S_SHIFT, S_INSERT, S_SCAN, S_FINISH
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [1:0]           op_q;
	logic [ID_BITS-1:0]   h_q;
	logic [ID_BITS-1:0]   d_q;
	logic [MASK_BITS-1:0] mask_q;
	logic [MASK_BITS-1:0] ev_q;
	logic [1:0]           status_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [CNT_W-1:0]     mid_q;
	logic [CNT_W-1:0]     cur_q;
	logic                 more_q;
	logic                 pend_s1;
	logic [CNT_W-1:0]     src_s1;
	logic                 pm_valid_q;
	logic [ID_BITS-1:0]   pm_h_q;
	logic [ID_BITS-1:0]   pm_d_q;
	logic [MATCH_W-1:0]   matches_q;

	logic                 is_add;
	logic                 is_del;
	logic [CNT_W:0]       mid_sum;
	logic [CNT_W-1:0]     mid;
	logic                 lo_lt_hi;
	logic                 key_lt;
	logic                 key_gt;
	logic                 match;
	logic                 stall;
	logic                 scan_done;
	logic [CNT_W-1:0]     cnt_m1;
	logic [CNT_W-1:0]     shift_dst;
	logic [CNT_W:0]       lo_p1;

	assign is_add   = (op_q == OP_ADD);
	assign is_del   = (op_q == OP_DEL);
	assign lo_lt_hi = (lo_q < hi_q);
	// Upper-bound search uses (lo+hi)/2 on a half-open range; delete probes the same
	// half-open range with the lower midpoint (lo+hi-1)/2 over the same registers
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{CNT_W{1'b0}}, is_del};
	assign mid      = mid_sum[CNT_W:1];
	assign key_lt   = {h_q, d_q} < {mem_rdata.handler, mem_rdata.data};
	assign key_gt   = {h_q, d_q} > {mem_rdata.handler, mem_rdata.data};
	assign match    = |(ev_q & mem_rdata.mask);
	assign stall    = pend_s1 && match && pm_valid_q && !push_ok;
	assign scan_done = (matches_q == MATCH_W'(RESULT_LIMIT)) || (!more_q && !pend_s1);
	assign cnt_m1   = count_q - 1'b1;
	assign shift_dst = is_add ? (src_s1 + 1'b1) : (src_s1 - 1'b1);
	assign lo_p1    = {1'b0, lo_q} + 1'b1;
	assign in_ready = (state_q == S_IDLE);

	// Memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cur_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = shift_dst[AW-1:0];
		mem_wdata = mem_rdata;
		unique case (state_q)
			S_PROBE: begin
				mem_re    = lo_lt_hi;
				mem_raddr = mid[AW-1:0];
			end
			S_SHIFT: begin
				mem_re = more_q;
				mem_we = pend_s1;
			end
			S_INSERT: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q[AW-1:0];
				mem_wdata = '{mask: mask_q, data: d_q, handler: h_q};
			end
			S_SCAN: begin
				mem_re = more_q && !scan_done && !stall;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Result toward the output register
	always_comb begin
		res_valid = 1'b0;
		res       = '{status: status_q, hit: 1'b0, handler: '0, data: '0, last: 1'b1};
		unique case (state_q)
			S_SCAN: begin
				res_valid = !scan_done && pend_s1 && match && pm_valid_q;
				res       = '{status: ST_OK, hit: 1'b1, handler: pm_h_q, data: pm_d_q,
					last: 1'b0};
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (pm_valid_q) begin
					res = '{status: ST_OK, hit: 1'b1, handler: pm_h_q, data: pm_d_q,
						last: 1'b1};
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			op_q       <= OP_ADD;
			h_q        <= '0;
			d_q        <= '0;
			mask_q     <= '0;
			ev_q       <= '0;
			status_q   <= ST_OK;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			cur_q      <= '0;
			more_q     <= 1'b0;
			pend_s1    <= 1'b0;
			src_s1     <= '0;
			pm_valid_q <= 1'b0;
			pm_h_q     <= '0;
			pm_d_q     <= '0;
			matches_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q       <= in_op;
						h_q        <= in_handler;
						d_q        <= in_data;
						mask_q     <= in_mask;
						ev_q       <= in_event;
						status_q   <= ST_OK;
						pm_valid_q <= 1'b0;
						matches_q  <= '0;
						pend_s1    <= 1'b0;
						lo_q       <= '0;
						hi_q       <= count_q;
						cur_q      <= '0;
						more_q     <= (count_q != '0);
						case (in_op)
							OP_ADD: begin
								if (count_q >= CNT_W'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_FINISH;
								end else begin
									state_q <= S_PROBE;
								end
							end
							OP_DEL:  state_q <= S_PROBE;
							OP_PROC: state_q <= S_SCAN;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_PROBE: begin
					if (lo_lt_hi) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else if (is_del) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_SH_INIT;
					end
				end
				S_CMP: begin
					state_q <= S_PROBE;
					if (key_lt) begin
						hi_q <= mid_q;
					end else if (key_gt || is_add) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						lo_q    <= mid_q;
						state_q <= S_SH_INIT;
					end
				end
				S_SH_INIT: begin
					pend_s1 <= 1'b0;
					if (is_add) begin
						cur_q  <= cnt_m1;
						more_q <= (count_q > lo_q);
					end else begin
						cur_q  <= lo_p1[CNT_W-1:0];
						more_q <= (lo_p1 < {1'b0, count_q});
					end
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					pend_s1 <= more_q;
					src_s1  <= cur_q;
					if (more_q) begin
						if (is_add) begin
							if (cur_q == lo_q) begin
								more_q <= 1'b0;
							end else begin
								cur_q <= cur_q - 1'b1;
							end
						end else begin
							if (cur_q == cnt_m1) begin
								more_q <= 1'b0;
							end else begin
								cur_q <= cur_q + 1'b1;
							end
						end
					end
					if (!more_q && !pend_s1) begin
						if (is_add) begin
							state_q <= S_INSERT;
						end else begin
							count_q <= cnt_m1;
							state_q <= S_FINISH;
						end
					end
				end
				S_INSERT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					if (scan_done) begin
						pend_s1 <= 1'b0;
						state_q <= S_FINISH;
					end else if (!stall) begin
						if (pend_s1 && match) begin
							pm_h_q     <= mem_rdata.handler;
							pm_d_q     <= mem_rdata.data;
							pm_valid_q <= 1'b1;
							matches_q  <= matches_q + 1'b1;
						end
						pend_s1 <= more_q;
						if (more_q) begin
							cur_q  <= cur_q + 1'b1;
							more_q <= (cur_q != cnt_m1);
						end
					end
				end
				S_FINISH: begin
					if (push_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sorted_subscription_filter_unit.sv =====
// Steps per item: add runs its search probes (at most $clog2(CAPACITY+1)), one closing
//   probe, the move set-up, the move of the entries above the slot, the write and the issue;
//   delete is alike but has no write and no closing probe when it finds the key; process
//   scans the entries and then issues its last item.
// Throughput: one item at a time, the next one accepted the cycle after the last result is
//   issued. Reset: arst_n clears the entry count and the sequencer; entries are not cleared,
//   no clearing pass.
`default_nettype none
module sorted_subscription_filter_unit #(
	parameter int CAPACITY = ssf_pkg::CAPACITY_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// handler_id [15:0], data_id [31:16], type_mask [63:32], event_type [95:64]
	input  wire logic [ssf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// operation [1:0]
	input  wire logic [ssf_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// match_handler [15:0], match_data [31:16]
	output logic [ssf_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// status [1:0], hit [2]
	output logic [ssf_pkg::M_TUSER_W-1:0]        m_axis_tuser,
	output logic                                 m_axis_tlast
);
	import ssf_pkg::*;

	localparam int AW = addr_w(CAPACITY);

	// Input item fields
	logic [ID_BITS-1:0]   in_handler;
	logic [ID_BITS-1:0]   in_data;
	logic [MASK_BITS-1:0] in_mask;
	logic [MASK_BITS-1:0] in_event;

	assign in_handler = s_axis_tdata[ID_BITS-1:0];
	assign in_data    = s_axis_tdata[2*ID_BITS-1:ID_BITS];
	assign in_mask    = s_axis_tdata[2*ID_BITS+MASK_BITS-1:2*ID_BITS];
	assign in_event   = s_axis_tdata[S_TDATA_W-1:2*ID_BITS+MASK_BITS];

	// Table memory port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	// Result hand-off to the output register
	logic    res_valid;
	result_t res;
	logic    push_ok;
	result_t out_res;

	// Sequencer: binary search, shift, insert and scan over the table
	ssf_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_handler (in_handler),
		.in_data    (in_data),
		.in_mask    (in_mask),
		.in_event   (in_event),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res        (res),
		.push_ok    (push_ok)
	);

	// Sorted subscription table, one entry per word
	ssf_table #(
		.CAPACITY (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Hold one result item; the sequencer goes on while the sink stalls until the next result must wait
	ssf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid && push_ok),
		.res       (res),
		.push_ok   (push_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.data, out_res.handler};
	assign m_axis_tuser = {out_res.hit, out_res.status};
	assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

// ===== hdl/ssf_checker.sv =====
`default_nettype none
module ssf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic [ssf_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input wire logic [ssf_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [ssf_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input wire logic [ssf_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input wire logic                          m_axis_tlast
);
	import ssf_pkg::*;

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// An item without a hit carries zero ids and closes its run
	a_miss_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("miss result not final or ids not zero");

	// A hit only comes from a scan, which always reports ok
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
		else $error("hit result with bad status");

	// Only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1:0] == ST_OK) || (m_axis_tuser[1:0] == ST_NOT_FOUND)
			|| (m_axis_tuser[1:0] == ST_FULL))
		else $error("undefined status code");

endmodule

bind sorted_subscription_filter_unit ssf_checker u_ssf_checker (.*);
`default_nettype wire
